// ----- src/frame_buffer_upscaler_defines.svh -----
// ---------------------------------------------------------------------------
// frame_buffer_upscaler_defines.svh
// Assertion macros for the frame buffer upscaler. Empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef FRAME_BUFFER_UPSCALER_DEFINES_SVH
`define FRAME_BUFFER_UPSCALER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset.
`define FBU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_buffer_upscaler: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FBU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_buffer_upscaler: check failed");

`else

`define FBU_ASSERT_NOW(label, ante, cons)
`define FBU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/fbu_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbu_pkg
// Shared constants and types of the frame buffer upscaler.
// ---------------------------------------------------------------------------
package fbu_pkg;

    localparam int FBU_FRAME_COLUMNS = 128;
    localparam int FBU_FRAME_ROWS    = 96;
    localparam int FBU_UPSCALE       = 4;
    localparam int FBU_PIXEL_BITS    = 24;

    // Width of the pixel ports and of the wide value that pixels are resized through.
    localparam int FBU_PORT_BITS     = 24;
    localparam int FBU_WIDE_BITS     = 64;

    // Per-beat markers from the read walker.
    typedef struct packed {
        logic frame_start;
        logic line_end;
    } fbu_flags_t;

endpackage

// ----- src/fbu_store_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbu_store_ram
// Frame store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fbu_store_ram
    import fbu_pkg::*;
#(
    parameter int DEPTH     = FBU_FRAME_COLUMNS * FBU_FRAME_ROWS,
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = FBU_PIXEL_BITS
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fbu_read_walk.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fbu_read_walk
// Read position walker: repeats pixels across and lines down, tracks the
// linear store address and raises the frame start / line end markers.
// ---------------------------------------------------------------------------
module fbu_read_walk
    import fbu_pkg::*;
#(
    parameter int FRAME_COLUMNS = FBU_FRAME_COLUMNS,
    parameter int FRAME_ROWS    = FBU_FRAME_ROWS,
    parameter int UPSCALE       = FBU_UPSCALE,
    parameter int ADDR_BITS     = 14
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    output logic [ADDR_BITS-1:0] rd_addr,
    output fbu_flags_t           flags
);

    localparam int COL_BITS = (FRAME_COLUMNS > 1) ? $clog2(FRAME_COLUMNS) : 1;
    localparam int ROW_BITS = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
    localparam int REP_BITS = (UPSCALE > 1) ? $clog2(UPSCALE) : 1;

    localparam logic [COL_BITS-1:0]  COL_LAST  = COL_BITS'(FRAME_COLUMNS - 1);
    localparam logic [ROW_BITS-1:0]  ROW_LAST  = ROW_BITS'(FRAME_ROWS - 1);
    localparam logic [REP_BITS-1:0]  REP_LAST  = REP_BITS'(UPSCALE - 1);
    localparam logic [ADDR_BITS-1:0] LINE_BACK = ADDR_BITS'(FRAME_COLUMNS - 1);

    logic [COL_BITS-1:0]  col_reg,  col_next;
    logic [ROW_BITS-1:0]  row_reg,  row_next;
    logic [REP_BITS-1:0]  hrep_reg, hrep_next;
    logic [REP_BITS-1:0]  vrep_reg, vrep_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;

    logic h_end, v_end, c_end, r_end, first;

    assign h_end = (hrep_reg == REP_LAST);
    assign v_end = (vrep_reg == REP_LAST);
    assign c_end = (col_reg == COL_LAST);
    assign r_end = (row_reg == ROW_LAST);
    assign first = (hrep_reg == '0) && (vrep_reg == '0) &&
                   (col_reg == '0) && (row_reg == '0);

    always_comb
    begin
        flags.frame_start = first;
        flags.line_end    = !first && h_end && c_end;
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        hrep_next = hrep_reg;
        vrep_next = vrep_reg;
        addr_next = addr_reg;
        if (advance)
        begin
            if (h_end)
            begin
                hrep_next = '0;
                col_next  = c_end ? '0 : col_reg + COL_BITS'(1);
                if (!c_end)
                begin
                    addr_next = addr_reg + ADDR_BITS'(1);
                end
                else if (!v_end)
                begin
                    // repeat the line: back to its first entry
                    addr_next = addr_reg - LINE_BACK;
                    vrep_next = vrep_reg + REP_BITS'(1);
                end
                else
                begin
                    vrep_next = '0;
                    row_next  = r_end ? '0 : row_reg + ROW_BITS'(1);
                    addr_next = r_end ? '0 : addr_reg + ADDR_BITS'(1);
                end
            end
            else
            begin
                hrep_next = hrep_reg + REP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            hrep_reg <= '0;
            vrep_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            hrep_reg <= hrep_next;
            vrep_reg <= vrep_next;
            addr_reg <= addr_next;
        end
    end

    assign rd_addr = addr_reg;

endmodule

// ----- src/frame_buffer_upscaler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_buffer_upscaler
// Frame store with nearest-neighbor upscaled raster readout.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per tick; pixel_valid marks a
//   pixel that is written at the raster write position, which then advances
//   and wraps at frame end. Every input beat yields exactly one output beat.
//   Output channel (out_valid/out_ready): out_pixel is the stored pixel at the
//   read position, each pixel shown UPSCALE times across and each line
//   UPSCALE times down; frame_start marks the first output pixel of a frame,
//   line_end the last pixel of each output line.
//   Path: an accepted input beat is registered in the read stage, then in
//   the output register, which drives the output channel.
//   Throughput: one beat per cycle while the output is not stalled; the read
//   port of the frame store takes one read per input beat.
//   Reset: after rst_n releases, a clearing pass zeroes the store, one entry
//   per cycle, all FRAME_COLUMNS*FRAME_ROWS entries (12288 by default); in_ready
//   stays low during that pass.
//   Stall: with out_ready low, one beat waits in the output register and one
//   more in the read stage; in_ready drops only when both are full.
// ---------------------------------------------------------------------------
`include "frame_buffer_upscaler_defines.svh"

module frame_buffer_upscaler
    import fbu_pkg::*;
#(
    parameter int FRAME_COLUMNS = FBU_FRAME_COLUMNS,
    parameter int FRAME_ROWS    = FBU_FRAME_ROWS,
    parameter int UPSCALE       = FBU_UPSCALE,
    parameter int PIXEL_BITS    = FBU_PIXEL_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     pixel_valid,
    input  logic [FBU_PORT_BITS-1:0] pixel_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FBU_PORT_BITS-1:0] out_pixel,
    output logic                     frame_start,
    output logic                     line_end
);

    localparam int DEPTH     = FRAME_COLUMNS * FRAME_ROWS;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(DEPTH - 1);

    // ---- handshake ----
    logic accept;
    logic s1_move;

    // ---- clearing pass ----
    logic                 clear_busy_reg, clear_busy_next;
    logic [ADDR_BITS-1:0] clear_addr_reg, clear_addr_next;

    // ---- write side ----
    logic [ADDR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FBU_WIDE_BITS-1:0] in_wide;
    logic [PIXEL_BITS-1:0] in_pix;
    logic                  mem_wr_en;
    logic [ADDR_BITS-1:0]  mem_wr_addr;
    logic [PIXEL_BITS-1:0] mem_wr_data;
    logic                  pix_write;

    // ---- read side ----
    logic [ADDR_BITS-1:0]  rd_addr;
    fbu_flags_t            walk_flags;
    logic [PIXEL_BITS-1:0] mem_rd_data;
    logic                  collide;

    // stage 1: memory read in flight
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_fwd_reg;
    logic [PIXEL_BITS-1:0] s1_fwd_data_reg;
    fbu_flags_t            s1_flags_reg;
    logic [PIXEL_BITS-1:0] s1_pix;
    logic [FBU_WIDE_BITS-1:0] s1_wide;

    // stage 2: output register
    logic                     out_valid_reg, out_valid_next;
    logic [FBU_PORT_BITS-1:0] out_pixel_reg;
    logic                     frame_start_reg;
    logic                     line_end_reg;

    // Read stage drains into the output register when that is free or leaving.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clear_busy_reg && (!s1_valid_reg || s1_move);
    assign accept   = in_valid && in_ready;

    // Stored pixel is the low PIXEL_BITS of the port value.
    assign in_wide   = FBU_WIDE_BITS'(pixel_value);
    assign in_pix    = in_wide[PIXEL_BITS-1:0];
    assign pix_write = accept && pixel_valid;

    // Same entry written and read in one beat: the new pixel wins.
    assign collide = pix_write && (wr_ptr_reg == rd_addr);

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_BITS'(1);
            if (clear_addr_reg == ADDR_LAST)
            begin
                clear_busy_next = 1'b0;
                clear_addr_next = '0;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (pix_write)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_LAST) ? '0 : wr_ptr_reg + ADDR_BITS'(1);
        end
    end

    // Clearing pass owns the write port; no input is taken meanwhile.
    always_comb
    begin
        mem_wr_en   = clear_busy_reg || pix_write;
        mem_wr_addr = clear_busy_reg ? clear_addr_reg : wr_ptr_reg;
        mem_wr_data = clear_busy_reg ? '0 : in_pix;
    end

    fbu_store_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (PIXEL_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    fbu_read_walk #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS),
        .UPSCALE       (UPSCALE),
        .ADDR_BITS     (ADDR_BITS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .rd_addr (rd_addr),
        .flags   (walk_flags)
    );

    assign s1_pix  = s1_fwd_reg ? s1_fwd_data_reg : mem_rd_data;
    assign s1_wide = FBU_WIDE_BITS'(s1_pix);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            wr_ptr_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            wr_ptr_reg     <= wr_ptr_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload, no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fwd_reg      <= collide;
            s1_fwd_data_reg <= in_pix;
            s1_flags_reg    <= walk_flags;
        end
        if (s1_move)
        begin
            out_pixel_reg   <= s1_wide[FBU_PORT_BITS-1:0];
            frame_start_reg <= s1_flags_reg.frame_start;
            line_end_reg    <= s1_flags_reg.line_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign frame_start = frame_start_reg;
    assign line_end    = line_end_reg;

    // ---- checks ----
    `FBU_ASSERT_NOW(a_no_accept_in_clear, clear_busy_reg, !in_ready)
    `FBU_ASSERT_NEXT(a_clear_ends, clear_busy_reg && (clear_addr_reg == ADDR_LAST), !clear_busy_reg)
    `FBU_ASSERT_NEXT(a_collide_forwards, accept && collide, s1_fwd_reg && s1_valid_reg)
    `FBU_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg)
    `FBU_ASSERT_NOW(a_flags_exclusive, out_valid_reg, !(frame_start_reg && line_end_reg))

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the frame buffer upscaler.
// Every input beat is run through a behavioral copy of the frame store and
// the upscaling read walk. The copy predicts the output beat that the input
// beat causes, and a scoreboard compares each accepted output beat with the
// oldest prediction. A short directed opening covers extreme pixel values,
// skipped ticks and writes that land on the entry being read. Random beats
// follow, with random gaps on the input side and random stalls on the
// output side.
// ---------------------------------------------------------------------------
module tb_top;
    import fbu_pkg::*;

    localparam int STORE_DEPTH = FBU_FRAME_COLUMNS * FBU_FRAME_ROWS;
    localparam int RANDOM_BEATS = 733;
    localparam int MAX_REPORTS = 10;

    // Bits of a pixel that the store keeps; the rest of the port reads as zero.
    localparam bit [FBU_PORT_BITS-1:0] PIXEL_MASK =
        FBU_PORT_BITS'((65'd1 << FBU_PIXEL_BITS) - 1);

    typedef bit [FBU_PORT_BITS-1:0] pixel_t;
    typedef bit [10:0] count_t;

    // One output beat as the block should present it.
    typedef struct {
        pixel_t pixel;
        bit     frame_start;
        bit     line_end;
    } upscaled_beat_t;

    // -----------------------------------------------------------------------
    // Scoreboard: keeps its own frame store and read walk, queues the
    // predicted output beat for each accepted input beat and checks the
    // output beats against that queue in order.
    // -----------------------------------------------------------------------
    class upscale_scoreboard;
        pixel_t         frame_mem [STORE_DEPTH];
        count_t         wr_col;
        count_t         wr_row;
        count_t         rd_col;
        count_t         rd_row;
        count_t         h_rep;
        count_t         v_rep;
        upscaled_beat_t expected_beats [$];
        int             mismatches;
        int             checked;
        int             pixels_stored;
        int             same_entry_hits;
        int             line_ends;
        int             frame_starts;

        function void clear();
            foreach (frame_mem[i])
                frame_mem[i] = '0;
            wr_col = '0;
            wr_row = '0;
            rd_col = '0;
            rd_row = '0;
            h_rep = '0;
            v_rep = '0;
            expected_beats.delete();
            mismatches = 0;
            checked = 0;
            pixels_stored = 0;
            same_entry_hits = 0;
            line_ends = 0;
            frame_starts = 0;
        endfunction

        // Step the store and the read walk by one accepted input beat.
        function void note_beat(bit pix_valid, pixel_t value);
            upscaled_beat_t exp_beat;
            bit h_end;
            bit v_end;
            bit c_end;
            bit r_end;

            // Write first: a read of the same entry sees the new pixel.
            if (pix_valid)
            begin
                if (wr_col == rd_col && wr_row == rd_row)
                    same_entry_hits++;
                if (wr_col < FBU_FRAME_COLUMNS && wr_row < FBU_FRAME_ROWS)
                    frame_mem[wr_row * FBU_FRAME_COLUMNS + wr_col] = value & PIXEL_MASK;
                pixels_stored++;
                if (wr_col == FBU_FRAME_COLUMNS - 1)
                begin
                    wr_col = '0;
                    if (wr_row == FBU_FRAME_ROWS - 1)
                        wr_row = '0;
                    else
                        wr_row = wr_row + 1'b1;
                end
                else
                begin
                    wr_col = wr_col + 1'b1;
                end
            end

            exp_beat.pixel = '0;
            if (rd_col < FBU_FRAME_COLUMNS && rd_row < FBU_FRAME_ROWS)
                exp_beat.pixel = frame_mem[rd_row * FBU_FRAME_COLUMNS + rd_col];

            h_end = (h_rep == FBU_UPSCALE - 1);
            v_end = (v_rep == FBU_UPSCALE - 1);
            c_end = (rd_col == FBU_FRAME_COLUMNS - 1);
            r_end = (rd_row == FBU_FRAME_ROWS - 1);

            // Frame start takes priority over line end.
            exp_beat.frame_start = (h_rep == 0 && v_rep == 0 && rd_col == 0 && rd_row == 0);
            exp_beat.line_end = !exp_beat.frame_start && h_end && c_end;
            expected_beats.push_back(exp_beat);

            if (h_end)
            begin
                h_rep = '0;
                if (c_end)
                    rd_col = '0;
                else
                    rd_col = rd_col + 1'b1;
            end
            else
            begin
                h_rep = h_rep + 1'b1;
            end
            if (h_end && c_end)
            begin
                if (v_end)
                begin
                    v_rep = '0;
                    if (r_end)
                        rd_row = '0;
                    else
                        rd_row = rd_row + 1'b1;
                end
                else
                begin
                    v_rep = v_rep + 1'b1;
                end
            end
        endfunction

        function void check_beat(pixel_t pixel, bit fs, bit le);
            upscaled_beat_t exp_beat;

            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] output beat with nothing expected: pixel %06h fs %0b le %0b",
                             $realtime, pixel, fs, le);
                return;
            end
            exp_beat = expected_beats.pop_front();
            checked++;
            if (exp_beat.frame_start)
                frame_starts++;
            if (exp_beat.line_end)
                line_ends++;
            if (pixel !== exp_beat.pixel || fs !== exp_beat.frame_start
                || le !== exp_beat.line_end)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] beat %0d: expected pixel %06h fs %0b le %0b, got pixel %06h fs %0b le %0b",
                             $realtime, checked - 1, exp_beat.pixel, exp_beat.frame_start,
                             exp_beat.line_end, pixel, fs, le);
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, DUT ports and instance
    // -----------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     pixel_valid;
    logic [FBU_PORT_BITS-1:0] pixel_value;
    logic                     out_valid;
    logic                     out_ready;
    logic [FBU_PORT_BITS-1:0] out_pixel;
    logic                     frame_start;
    logic                     line_end;

    upscale_scoreboard sb;
    bit                calm_phase;   // no gaps or stalls while set
    int                beats_sent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    frame_buffer_upscaler u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_valid (pixel_valid),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pixel   (out_pixel),
        .frame_start (frame_start),
        .line_end    (line_end)
    );

    // -----------------------------------------------------------------------
    // Input side: optional gap, then hold the beat until in_ready.
    // Drive at the falling edge; the handshake is seen at the rising edge
    // with pre-edge values. With no gap, in_valid simply stays high and
    // only the payload changes.
    // -----------------------------------------------------------------------
    task automatic send_beat(input bit pix_valid, input pixel_t value);
        int gap;

        gap = calm_phase ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        pixel_valid = pix_valid;
        pixel_value = value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(pix_valid, value);
        beats_sent++;
    endtask

    // -----------------------------------------------------------------------
    // Output side: random stall before each beat, then ready until taken.
    // -----------------------------------------------------------------------
    initial
    begin : receiver
        int stall;

        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm_phase ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_beat(out_pixel, frame_start, line_end);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        bit dense_phase;
        int drain_cycles;

        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_valid = 1'b0;
        pixel_value = '0;
        calm_phase = 1'b0;
        dense_phase = 1'b0;
        beats_sent = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        // in_ready stays low through the clearing pass; send_beat waits it out.

        // Directed opening. The read walk moves one column every UPSCALE
        // beats, so a write lands on the entry being read at beat 0, and
        // again at beats 8 and 12 once skipped ticks let the read catch up.
        send_beat(1'b1, 24'hFFFFFF);   // write and read of (0,0) together
        send_beat(1'b1, 24'h000000);
        send_beat(1'b0, 24'hABCDEF);   // skipped ticks: value must be dropped
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b0, 24'h000000);
        send_beat(1'b0, 24'h123456);
        send_beat(1'b0, 24'h800000);
        send_beat(1'b0, 24'h000001);
        send_beat(1'b1, 24'h800000);   // write and read of (2,0) together
        send_beat(1'b0, 24'h7FFFFF);
        send_beat(1'b0, 24'hFEFEFE);
        send_beat(1'b0, 24'h010101);
        send_beat(1'b1, 24'h000001);   // write and read of (3,0) together
        send_beat(1'b1, 24'h555555);
        send_beat(1'b1, 24'hAAAAAA);
        send_beat(1'b1, 24'h7FFFFF);
        send_beat(1'b1, 24'hFFFFFE);

        // Random part. Sparse phases keep the write position near the read
        // walk so same-entry hits keep coming; dense phases run ahead of it.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 96 == 0)
            begin
                calm_phase = ($urandom_range(0, 3) == 0);
                dense_phase = ($urandom_range(0, 2) == 0);
            end
            if (dense_phase)
                send_beat(1'($urandom_range(0, 1)), pixel_t'($urandom()));
            else
                send_beat($urandom_range(0, 3) == 0, pixel_t'($urandom()));
        end
        @(negedge clk);
        in_valid = 1'b0;
        calm_phase = 1'b0;

        // Drain: wait for the outstanding beats, then keep clocking to catch
        // any extra beat that arrives behind them.
        drain_cycles = 0;
        while (sb.pending() > 0 && drain_cycles < 2000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);

        if (sb.pending() > 0)
            $display("%0d expected output beats never arrived", sb.pending());
        $display("Run: %0d input beats, %0d pixels stored, %0d output beats checked",
                 beats_sent, sb.pixels_stored, sb.checked);
        $display("Seen: %0d same-entry write/read ticks, %0d line ends, %0d frame starts",
                 sb.same_entry_hits, sb.line_ends, sb.frame_starts);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: covers the clearing pass and the slowest gap/stall pattern
    // many times over.
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout after %0t, %0d beats still expected", $realtime, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
